>>> rtl/fcsg_pkg.sv
package fcsg_pkg;

	// Radius field and walk register widths
	localparam int RADIUS_W  = 7;
	localparam int DEC_W     = 12;
	localparam int STEP_CNT_W = 7;
	localparam int MAX_STEPS = 64;

	// Midpoint walk constants
	localparam int DEC_INIT   = 3;
	localparam int DEC_INC_E  = 6;
	localparam int DEC_INC_SE = 10;

	// Back-end walk sequencer
	typedef enum logic [0:0] {
		WALK_IDLE,
		WALK_RUN
	} walk_state_t;

endpackage

>>> rtl/fcsg_front.sv
module fcsg_front import fcsg_pkg::*; #(
	parameter int MAX_RADIUS  = 88,
	parameter int COORD_WIDTH = 13,
	parameter int CMD_W       = 2 * COORD_WIDTH + RADIUS_W + DEC_W
) (
	input  logic                         cmd_in_valid,
	output logic                         cmd_in_ready,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic        [RADIUS_W-1:0]    radius,
	output logic                         cmd_out_valid,
	input  logic                         cmd_out_ready,
	output logic        [CMD_W-1:0]       cmd_out_data
);

	logic        [RADIUS_W-1:0] radius_sat;
	logic signed [DEC_W-1:0]    dec_init;

	// Clamp the radius to the largest supported circle
	always_comb begin
		if (radius > RADIUS_W'(MAX_RADIUS)) begin
			radius_sat = RADIUS_W'(MAX_RADIUS);
		end else begin
			radius_sat = radius;
		end
	end

	// Seed the decision term with 3 - 2r
	assign dec_init = DEC_W'(DEC_INIT) - {{(DEC_W-RADIUS_W-1){1'b0}}, radius_sat, 1'b0};

	// Hand the prepared command to the queue
	assign cmd_out_valid = cmd_in_valid;
	assign cmd_in_ready  = cmd_out_ready;
	assign cmd_out_data  = {dec_init, radius_sat, center_y, center_x};

endmodule

>>> rtl/fcsg_cmd_queue.sv
module fcsg_cmd_queue #(
	parameter int WIDTH = 45
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the incoming command
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

>>> rtl/fcsg_walker.sv
module fcsg_walker import fcsg_pkg::*; #(
	parameter int COORD_WIDTH = 13,
	parameter int CMD_W       = 2 * COORD_WIDTH + RADIUS_W + DEC_W,
	parameter int OUT_W       = COORD_WIDTH + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  logic [CMD_W-1:0]       cmd_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_W-1:0]       narrow_left,
	output logic [OUT_W-1:0]       narrow_right,
	output logic [OUT_W-1:0]       narrow_upper_row,
	output logic [OUT_W-1:0]       narrow_lower_row,
	output logic [OUT_W-1:0]       wide_left,
	output logic [OUT_W-1:0]       wide_right,
	output logic [OUT_W-1:0]       wide_upper_row,
	output logic [OUT_W-1:0]       wide_lower_row,
	output logic                   last_step
);

	walk_state_t state_q, state_d;

	logic        [RADIUS_W-1:0]    x_q, y_q;
	logic signed [DEC_W-1:0]       dec_q;
	logic        [COORD_WIDTH-1:0] cx_q, cy_q;
	logic        [STEP_CNT_W-1:0]  cnt_q;
	logic                          out_valid_q;

	logic                          out_free;
	logic                          step_en;
	logic                          load;
	logic                          go_diag;
	logic        [RADIUS_W:0]      x_inc1;
	logic        [RADIUS_W:0]      y_wide;
	logic        [STEP_CNT_W-1:0]  cnt_next;
	logic                          last_w;
	logic signed [RADIUS_W:0]      x_minus_y;
	logic signed [DEC_W-1:0]       dec_next;
	logic        [OUT_W-1:0]       cx_ext, cy_ext, x_ext, y_ext;

	// Unpacked command fields
	logic        [COORD_WIDTH-1:0] cmd_cx, cmd_cy;
	logic        [RADIUS_W-1:0]    cmd_r;
	logic        [DEC_W-1:0]       cmd_dec;

	assign {cmd_dec, cmd_r, cmd_cy, cmd_cx} = cmd_data;

	assign out_free = !out_valid_q || out_ready;
	assign load     = cmd_valid && cmd_ready;

	// Next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			WALK_IDLE: state_d = cmd_valid ? WALK_RUN : WALK_IDLE;
			WALK_RUN:  state_d = (step_en && last_w) ? WALK_IDLE : WALK_RUN;
			default:   state_d = WALK_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		cmd_ready = 1'b0;
		step_en   = 1'b0;
		unique case (state_q)
			WALK_IDLE: cmd_ready = 1'b1;
			WALK_RUN:  step_en   = out_free;
			default: begin
				cmd_ready = 1'b0;
				step_en   = 1'b0;
			end
		endcase
	end

	// Midpoint step: pick the move, update decision, detect the octant end
	assign go_diag   = !dec_q[DEC_W-1];
	assign x_inc1    = {1'b0, x_q} + (RADIUS_W+1)'(1);
	assign y_wide    = {1'b0, y_q};
	assign cnt_next  = cnt_q + STEP_CNT_W'(1);
	assign x_minus_y = $signed({1'b0, x_q}) - $signed({1'b0, y_q});
	assign last_w    = (go_diag ? (y_wide <= x_inc1) : (y_q <= x_q))
	                   || (cnt_next == STEP_CNT_W'(MAX_STEPS));

	always_comb begin
		if (go_diag) begin
			dec_next = dec_q
			           + ({{(DEC_W-RADIUS_W-1){x_minus_y[RADIUS_W]}}, x_minus_y} <<< 2)
			           + DEC_W'(DEC_INC_SE);
		end else begin
			dec_next = dec_q
			           + {{(DEC_W-RADIUS_W-2){1'b0}}, x_q, 2'b00}
			           + DEC_W'(DEC_INC_E);
		end
	end

	// Span end points at the output width
	assign cx_ext = {cx_q[COORD_WIDTH-1], cx_q};
	assign cy_ext = {cy_q[COORD_WIDTH-1], cy_q};
	assign x_ext  = {{(OUT_W-RADIUS_W){1'b0}}, x_q};
	assign y_ext  = {{(OUT_W-RADIUS_W){1'b0}}, y_q};

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= WALK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (step_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers: load on a new command, advance on each step
	always_ff @(posedge clk) begin
		if (load) begin
			cx_q  <= cmd_cx;
			cy_q  <= cmd_cy;
			x_q   <= '0;
			y_q   <= cmd_r;
			dec_q <= cmd_dec;
			cnt_q <= '0;
		end else if (step_en) begin
			x_q   <= x_inc1[RADIUS_W-1:0];
			y_q   <= go_diag ? (y_q - RADIUS_W'(1)) : y_q;
			dec_q <= dec_next;
			cnt_q <= cnt_next;
		end
	end

	// Output register: hold until the downstream side takes the transaction
	always_ff @(posedge clk) begin
		if (step_en) begin
			narrow_left      <= cx_ext - x_ext;
			narrow_right     <= cx_ext + x_ext;
			narrow_upper_row <= cy_ext - y_ext;
			narrow_lower_row <= cy_ext + y_ext;
			wide_left        <= cx_ext - y_ext;
			wide_right       <= cx_ext + y_ext;
			wide_upper_row   <= cy_ext - x_ext;
			wide_lower_row   <= cy_ext + x_ext;
			last_step        <= last_w;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/filled_circle_span_generator.sv
// Filled circle span generator. Each slave transaction is one circle command
// (centre and radius, radius clamped to MAX_RADIUS); the block walks one octant
// of the midpoint circle and sends one master transaction per octant step,
// carrying a narrow and a wide pair of horizontal fill spans, with tlast on the
// final step. A circle of radius r gives about r/1.414 + 1 steps, never more
// than 64, at one step per clock while the master side accepts; the step
// sequencer goes idle to pick up each command. Commands wait in a two-deep
// queue, so up to two more can be taken while a circle is still being walked.
module filled_circle_span_generator import fcsg_pkg::*; #(
	parameter int MAX_RADIUS  = 88,
	parameter int COORD_WIDTH = 13
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// center_x, center_y, radius from bit 0 up
	input  logic [((2*COORD_WIDTH+RADIUS_W+7)/8)*8-1:0] s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// narrow_left, narrow_right, narrow_upper_row, narrow_lower_row,
	// wide_left, wide_right, wide_upper_row, wide_lower_row from bit 0 up
	output logic [((8*(COORD_WIDTH+1)+7)/8)*8-1:0] m_tdata,
	output logic m_tlast
);

	localparam int IN_BITS  = 2 * COORD_WIDTH + RADIUS_W;
	localparam int OUT_W    = COORD_WIDTH + 1;
	localparam int OUT_BITS = 8 * OUT_W;
	localparam int OUTD_W   = ((OUT_BITS + 7) / 8) * 8;
	localparam int CMD_W    = 2 * COORD_WIDTH + RADIUS_W + DEC_W;

	logic [COORD_WIDTH-1:0] center_x, center_y;
	logic [RADIUS_W-1:0]    radius;
	logic                   fq_valid, fq_ready;
	logic [CMD_W-1:0]       fq_data;
	logic                   qw_valid, qw_ready;
	logic [CMD_W-1:0]       qw_data;
	logic [OUT_W-1:0]       narrow_left, narrow_right, narrow_upper_row, narrow_lower_row;
	logic [OUT_W-1:0]       wide_left, wide_right, wide_upper_row, wide_lower_row;

	// Split the slave payload
	assign center_x = s_tdata[COORD_WIDTH-1:0];
	assign center_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign radius   = s_tdata[IN_BITS-1:2*COORD_WIDTH];

	fcsg_front #(
		.MAX_RADIUS  (MAX_RADIUS),
		.COORD_WIDTH (COORD_WIDTH),
		.CMD_W       (CMD_W)
	) u_front (
		.cmd_in_valid  (s_tvalid),
		.cmd_in_ready  (s_tready),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius        (radius),
		.cmd_out_valid (fq_valid),
		.cmd_out_ready (fq_ready),
		.cmd_out_data  (fq_data)
	);

	fcsg_cmd_queue #(
		.WIDTH (CMD_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qw_valid),
		.out_ready (qw_ready),
		.out_data  (qw_data)
	);

	fcsg_walker #(
		.COORD_WIDTH (COORD_WIDTH),
		.CMD_W       (CMD_W),
		.OUT_W       (OUT_W)
	) u_walker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (qw_valid),
		.cmd_ready        (qw_ready),
		.cmd_data         (qw_data),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.narrow_left      (narrow_left),
		.narrow_right     (narrow_right),
		.narrow_upper_row (narrow_upper_row),
		.narrow_lower_row (narrow_lower_row),
		.wide_left        (wide_left),
		.wide_right       (wide_right),
		.wide_upper_row   (wide_upper_row),
		.wide_lower_row   (wide_lower_row),
		.last_step        (m_tlast)
	);

	// Pack the master payload, zero fill to whole bytes
	assign m_tdata = OUTD_W'({wide_lower_row, wide_upper_row, wide_right, wide_left,
	                          narrow_lower_row, narrow_upper_row, narrow_right, narrow_left});

endmodule

>>> rtl/fcsg_checker.sv
module fcsg_checker #(
	parameter int COORD_WIDTH = 13
) (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((8*(COORD_WIDTH+1)+7)/8)*8-1:0] m_tdata,
	input logic m_tlast
);

	localparam int OW = COORD_WIDTH + 1;

	logic [OW-1:0] n_l, n_r, n_u, n_d, w_l, w_r, w_u, w_d;

	assign n_l = m_tdata[OW-1:0];
	assign n_r = m_tdata[2*OW-1:OW];
	assign n_u = m_tdata[3*OW-1:2*OW];
	assign n_d = m_tdata[4*OW-1:3*OW];
	assign w_l = m_tdata[5*OW-1:4*OW];
	assign w_r = m_tdata[6*OW-1:5*OW];
	assign w_u = m_tdata[7*OW-1:6*OW];
	assign w_d = m_tdata[8*OW-1:7*OW];

	// A stalled transaction keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled span transaction changed");

	// Both span pairs are centred on the same column
	a_col_centre: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> OW'(n_l + n_r) == OW'(w_l + w_r))
		else $error("span pairs disagree on centre column");

	// Both row pairs are centred on the same row
	a_row_centre: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> OW'(n_u + n_d) == OW'(w_u + w_d))
		else $error("span pairs disagree on centre row");

	// Narrow span width matches the wide pair row spread
	a_swap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> OW'(n_r - n_l) == OW'(w_d - w_u))
		else $error("step x differs between span pairs");

	// Within a circle the next step follows right after each taken step
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a circle walk");

endmodule

bind filled_circle_span_generator fcsg_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_fcsg_checker (.*);
